// ----- hdl/coprime_pair_counter_top_assert.svh -----
// assertion macros for the coprime pair counter checker
// needs nothing but a clock and an active-low reset at each use
`ifndef COPRIME_PAIR_COUNTER_TOP_ASSERT_SVH
`define COPRIME_PAIR_COUNTER_TOP_ASSERT_SVH

// same-cycle implication, disabled in reset
`define CPC_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, disabled in reset
`define CPC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- hdl/cpc_pkg.sv -----
// shared constants and types of the coprime pair counter
// no dependencies
`default_nettype none

package cpc_pkg;

    localparam int MAX_BYTES_DEF   = 8;
    localparam int COUNT_WIDTH_DEF = 48;

    localparam int BYTE_W      = 8;
    localparam int CFG_W       = 4;
    localparam int OUT_CNT_W   = 48;
    localparam int QUEUE_DEPTH = 2;

    // verdict, coprime total, non-coprime total, padded to whole bytes
    localparam int OUT_BITS    = 1 + 2 * OUT_CNT_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [CFG_W-1:0] CFG_RESET = 4'd5;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_RUN,
        BK_DONE
    } t_back_state;

endpackage

`default_nettype wire

// ----- hdl/coprime_pair_counter_top.sv -----
// Coprime pair counter, top level: byte stream in, one result per pair out.
// Depends on cpc_pkg, cpc_front, cpc_queue and cpc_back.
//
// Usage:
//   Slave stream carries one random byte per request, most significant byte
//   of each number first. Every 2*L bytes (L = bytes_per_number, 0 read as 1,
//   above MAX_BYTES read as MAX_BYTES) make one pair. The master stream
//   carries one result per pair: verdict and both saturating counts.
//   The length register is to be written with i_cfg_we only while the block
//   is idle; the user must keep to this, the block has no check for it. The
//   packer takes one byte per cycle unless the queue is full and the byte
//   would complete a pair. The gcd engine loads a pair, then does one binary
//   gcd step per cycle until one number is zero or both are even, and then
//   updates the counters once the output register is free. A two-entry pair
//   queue lets the packer run ahead of the engine.
//   Reset clears the counts, the packing position and the queue, and sets
//   L to 5. A stalled receiver holds the result in the output register; the
//   engine then waits, the queue fills, and only the byte that would
//   complete a third waiting pair is held off.
`default_nettype none

module coprime_pair_counter_top #(
    parameter int MAX_BYTES   = cpc_pkg::MAX_BYTES_DEF,
    parameter int COUNT_WIDTH = cpc_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [cpc_pkg::CFG_W-1:0]      i_cfg_wdata,  // bytes_per_number
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [cpc_pkg::BYTE_W-1:0]     s_axis_tdata, // data_byte
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // pair_coprime [0], coprime_total [48:1], not_coprime_total [96:49], zero pad
    output logic [cpc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);
    import cpc_pkg::*;

    localparam int PAIR_W = 2 * BYTE_W * MAX_BYTES;

    logic              q_push;
    logic              q_full;
    logic              q_pop;
    logic              q_empty;
    logic [PAIR_W-1:0] q_in_data;
    logic [PAIR_W-1:0] q_out_data;

    cpc_front #(
        .MAX_BYTES (MAX_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (s_axis_tvalid),
        .o_s_tready  (s_axis_tready),
        .i_s_tdata   (s_axis_tdata),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_data    (q_in_data)
    );

    cpc_queue #(
        .WIDTH (PAIR_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in_data),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_out_data)
    );

    cpc_back #(
        .MAX_BYTES   (MAX_BYTES),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (q_empty),
        .o_q_pop    (q_pop),
        .i_q_data   (q_out_data),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_m_tdata  (m_axis_tdata)
    );

endmodule

`default_nettype wire

// ----- hdl/cpc_front.sv -----
// front end: length register, byte packer, pair hand-off to the queue
// depends on cpc_pkg
`default_nettype none

module cpc_front #(
    parameter int MAX_BYTES = cpc_pkg::MAX_BYTES_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [cpc_pkg::CFG_W-1:0]        i_cfg_wdata,
    input  wire logic                             i_s_tvalid,
    output logic                                  o_s_tready,
    input  wire logic [cpc_pkg::BYTE_W-1:0]       i_s_tdata,
    input  wire logic                             i_q_full,
    output logic                                  o_q_push,
    output logic [2*cpc_pkg::BYTE_W*MAX_BYTES-1:0] o_q_data
);
    import cpc_pkg::*;

    localparam int NUM_W = BYTE_W * MAX_BYTES;

    logic [CFG_W-1:0] r_cfg;
    logic [NUM_W-1:0] r_first, n_first;
    logic [NUM_W-1:0] r_second, n_second;
    logic [CFG_W-1:0] r_pos;
    logic             r_fill_second;

    logic [CFG_W-1:0] len;
    logic             last_byte;
    logic             accept;
    logic [NUM_W-1:0] byte_ext;

    always_comb begin
        if (r_cfg == '0) begin
            len = CFG_W'(1);
        end else if (r_cfg > CFG_W'(MAX_BYTES)) begin
            len = CFG_W'(MAX_BYTES);
        end else begin
            len = r_cfg;
        end
    end

    assign last_byte  = ({1'b0, r_pos} + 5'd1) >= {1'b0, len};
    assign o_s_tready = !(r_fill_second && last_byte && i_q_full);
    assign accept     = i_s_tvalid && o_s_tready;
    assign byte_ext   = NUM_W'(i_s_tdata);

    // big-endian packing, a fresh number starts at position zero
    assign n_first  = (r_pos == '0) ? byte_ext : ((r_first << BYTE_W) | byte_ext);
    assign n_second = (r_pos == '0) ? byte_ext : ((r_second << BYTE_W) | byte_ext);

    assign o_q_push = accept && r_fill_second && last_byte;
    assign o_q_data = {r_first, n_second};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg         <= CFG_RESET;
            r_pos         <= '0;
            r_fill_second <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
            if (accept) begin
                r_pos         <= last_byte ? '0 : r_pos + CFG_W'(1);
                r_fill_second <= last_byte ? !r_fill_second : r_fill_second;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && !r_fill_second) begin
            r_first <= n_first;
        end
        if (accept && r_fill_second) begin
            r_second <= n_second;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/cpc_queue.sv -----
// two-entry pair queue between the packer and the gcd engine
// depends on cpc_pkg
`default_nettype none

module cpc_queue #(
    parameter int WIDTH = 2 * cpc_pkg::BYTE_W * cpc_pkg::MAX_BYTES_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_empty,
    output logic [WIDTH-1:0]      o_data
);
    import cpc_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] r_entry [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = r_count == CNT_W'(QUEUE_DEPTH);
    assign o_empty = r_count == '0;
    assign o_data  = r_entry[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/cpc_back.sv -----
// back end: binary gcd engine, saturating counters, output register
// depends on cpc_pkg
`default_nettype none

module cpc_back #(
    parameter int MAX_BYTES   = cpc_pkg::MAX_BYTES_DEF,
    parameter int COUNT_WIDTH = cpc_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_q_empty,
    output logic                                        o_q_pop,
    input  wire logic [2*cpc_pkg::BYTE_W*MAX_BYTES-1:0] i_q_data,
    output logic                                        o_m_tvalid,
    input  wire logic                                   i_m_tready,
    output logic [cpc_pkg::OUT_TDATA_W-1:0]             o_m_tdata
);
    import cpc_pkg::*;

    localparam int NUM_W = BYTE_W * MAX_BYTES;
    localparam int EXT_W = (COUNT_WIDTH > OUT_CNT_W) ? COUNT_WIDTH : OUT_CNT_W;

    t_back_state r_state, n_state;

    logic [NUM_W-1:0]       r_a, n_a;
    logic [NUM_W-1:0]       r_b, n_b;
    logic                   r_cop;
    logic [COUNT_WIDTH-1:0] r_cop_cnt, n_cop_cnt;
    logic [COUNT_WIDTH-1:0] r_ncop_cnt, n_ncop_cnt;
    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;

    logic                   gcd_done;
    logic                   gcd_is_one;
    logic [NUM_W:0]         a_minus_b;
    logic [NUM_W-1:0]       b_minus_a;
    logic                   out_free;
    logic                   load;
    logic                   finish;
    logic [EXT_W-1:0]       cop_ext;
    logic [EXT_W-1:0]       ncop_ext;

    assign a_minus_b = {1'b0, r_a} - {1'b0, r_b};
    assign b_minus_a = r_b - r_a;
    assign out_free  = !r_out_valid || i_m_tready;

    // done when one side is zero (gcd is the other side), or both even (gcd is then even)
    always_comb begin
        gcd_done   = 1'b0;
        gcd_is_one = 1'b0;
        if (r_b == '0) begin
            gcd_done   = 1'b1;
            gcd_is_one = r_a == NUM_W'(1);
        end else if (r_a == '0) begin
            gcd_done   = 1'b1;
            gcd_is_one = r_b == NUM_W'(1);
        end else if (!r_a[0] && !r_b[0]) begin
            gcd_done   = 1'b1;
        end
    end

    // one step: strip a factor of two from the even side, else subtract
    always_comb begin
        n_a = r_a;
        n_b = r_b;
        if (load) begin
            n_a = i_q_data[2*NUM_W-1:NUM_W];
            n_b = i_q_data[NUM_W-1:0];
        end else if (r_state == BK_RUN && !gcd_done) begin
            if (!r_a[0]) begin
                n_a = r_a >> 1;
            end else if (!r_b[0]) begin
                n_b = r_b >> 1;
            end else if (a_minus_b[NUM_W]) begin
                n_b = b_minus_a;
            end else begin
                n_a = a_minus_b[NUM_W-1:0];
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (!i_q_empty) begin
                    n_state = BK_RUN;
                end
            end
            BK_RUN: begin
                if (gcd_done) begin
                    n_state = BK_DONE;
                end
            end
            BK_DONE: begin
                if (out_free) begin
                    n_state = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_comb begin
        load   = 1'b0;
        finish = 1'b0;
        case (r_state)
            BK_IDLE: begin
                load = !i_q_empty;
            end
            BK_DONE: begin
                finish = out_free;
            end
            default: begin
                load   = 1'b0;
                finish = 1'b0;
            end
        endcase
    end

    assign o_q_pop = load;

    always_comb begin
        n_cop_cnt  = r_cop_cnt;
        n_ncop_cnt = r_ncop_cnt;
        if (r_cop) begin
            if (r_cop_cnt != '1) begin
                n_cop_cnt = r_cop_cnt + COUNT_WIDTH'(1);
            end
        end else begin
            if (r_ncop_cnt != '1) begin
                n_ncop_cnt = r_ncop_cnt + COUNT_WIDTH'(1);
            end
        end
    end

    assign cop_ext  = EXT_W'(n_cop_cnt);
    assign ncop_ext = EXT_W'(n_ncop_cnt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_cop_cnt   <= '0;
            r_ncop_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (finish) begin
                r_cop_cnt   <= n_cop_cnt;
                r_ncop_cnt  <= n_ncop_cnt;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_a <= n_a;
        r_b <= n_b;
        if (r_state == BK_RUN && gcd_done) begin
            r_cop <= gcd_is_one;
        end
        if (finish) begin
            r_out_data <= OUT_TDATA_W'({ncop_ext[OUT_CNT_W-1:0], cop_ext[OUT_CNT_W-1:0], r_cop});
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

`default_nettype wire

// ----- hdl/cpc_checker.sv -----
// port-level checks on the coprime pair counter, bound to the top level
// depends on cpc_pkg and coprime_pair_counter_top_assert.svh
`default_nettype none

`include "coprime_pair_counter_top_assert.svh"

module cpc_checker (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       m_axis_tvalid,
    input wire logic                       m_axis_tready,
    input wire logic [cpc_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import cpc_pkg::*;

    // a pending result stays offered with the same contents
    `CPC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `CPC_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))

    // the count for the verdict just given includes this pair
    `CPC_ASSERT_NOW(a_cop_counted, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[0], m_axis_tdata[OUT_CNT_W:1] != '0)
    `CPC_ASSERT_NOW(a_ncop_counted, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tdata[0], m_axis_tdata[2*OUT_CNT_W:OUT_CNT_W+1] != '0)

endmodule

bind coprime_pair_counter_top cpc_checker u_cpc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ----- sim/coprime_pair_counter_top_tb.sv -----
// self-checking bench for coprime_pair_counter_top: bytes in, one gcd verdict per pair out
// depends on cpc_pkg and coprime_pair_counter_top; a local tally predicts each verdict
`default_nettype none

module coprime_pair_counter_top_tb;
    import cpc_pkg::*;

    localparam int SETTLE_CYCLES = 2 * 8 * MAX_BYTES_DEF + 12;
    localparam int LONG_HOLD     = 300;
    localparam int LIMIT_CYCLES  = 400000;

    typedef struct {
        logic                 coprime;
        logic [OUT_CNT_W-1:0] coprime_total;
        logic [OUT_CNT_W-1:0] not_coprime_total;
    } t_verdict;

    // tracks packing position and pair counts, queues the verdict each pair should produce
    class coprime_tally;
        logic [CFG_W-1:0]     length_reg;
        logic [63:0]          first_num;
        logic [63:0]          second_num;
        logic [3:0]           byte_pos;
        logic                 filling_second;
        logic [OUT_CNT_W-1:0] coprime_cnt;
        logic [OUT_CNT_W-1:0] not_coprime_cnt;
        t_verdict             verdicts_due[$];
        int                   errors;

        function new();
            length_reg      = CFG_RESET;
            first_num       = '0;
            second_num      = '0;
            byte_pos        = '0;
            filling_second  = 1'b0;
            coprime_cnt     = '0;
            not_coprime_cnt = '0;
            errors          = 0;
        endfunction

        static function int effective_length(logic [CFG_W-1:0] v);
            if (v == 0) begin
                return 1;
            end
            return (v > MAX_BYTES_DEF) ? MAX_BYTES_DEF : int'(v);
        endfunction

        function void set_length(logic [CFG_W-1:0] v);
            length_reg = v;
        endfunction

        function logic [63:0] euclid_gcd(logic [63:0] a, logic [63:0] b);
            logic [63:0] r;
            while (b != 0) begin
                r = a % b;
                a = b;
                b = r;
            end
            return a;
        endfunction

        function void take_byte(logic [7:0] b);
            int          eff;
            t_verdict    v;
            eff = effective_length(length_reg);
            if (!filling_second) begin
                first_num = (byte_pos == 0) ? {56'd0, b} : {first_num[55:0], b};
            end else begin
                second_num = (byte_pos == 0) ? {56'd0, b} : {second_num[55:0], b};
            end
            // a length shortened mid-number completes it on this byte
            if (int'(byte_pos) + 1 < eff) begin
                byte_pos = byte_pos + 1'b1;
                return;
            end
            byte_pos = '0;
            if (!filling_second) begin
                filling_second = 1'b1;
                return;
            end
            filling_second = 1'b0;
            // gcd(0,0) = 0 lands on the not-coprime side
            v.coprime = (euclid_gcd(first_num, second_num) == 64'd1);
            if (v.coprime) begin
                if (coprime_cnt != '1) coprime_cnt = coprime_cnt + 1'b1;
            end else begin
                if (not_coprime_cnt != '1) not_coprime_cnt = not_coprime_cnt + 1'b1;
            end
            v.coprime_total     = coprime_cnt;
            v.not_coprime_total = not_coprime_cnt;
            verdicts_due.push_back(v);
        endfunction

        function void check_verdict(logic [OUT_TDATA_W-1:0] data);
            t_verdict             want;
            logic                 got_cop;
            logic [OUT_CNT_W-1:0] got_cop_tot;
            logic [OUT_CNT_W-1:0] got_ncop_tot;
            got_cop      = data[0];
            got_cop_tot  = data[OUT_CNT_W:1];
            got_ncop_tot = data[2*OUT_CNT_W:OUT_CNT_W+1];
            if (verdicts_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, no pair pending, got %h", $time, data);
                return;
            end
            want = verdicts_due.pop_front();
            if (got_cop !== want.coprime) begin
                errors++;
                $display("%0t: pair_coprime expected %0d got %0d",
                         $time, want.coprime, got_cop);
            end
            if (got_cop_tot !== want.coprime_total) begin
                errors++;
                $display("%0t: coprime_total expected %0d got %0d",
                         $time, want.coprime_total, got_cop_tot);
            end
            if (got_ncop_tot !== want.not_coprime_total) begin
                errors++;
                $display("%0t: not_coprime_total expected %0d got %0d",
                         $time, want.not_coprime_total, got_ncop_tot);
            end
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_W-1:0]       i_cfg_wdata = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [BYTE_W-1:0]      s_axis_tdata = '0;   // data_byte
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // pair_coprime [0], coprime_total [48:1], not_coprime_total [96:49], zero pad
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    coprime_tally board = new();
    bit  send_steady;
    bit  recv_steady;
    bit  long_hold_req;
    int  cycle_count;

    coprime_pair_counter_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    task automatic write_length(input logic [CFG_W-1:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        board.set_length(v);
    endtask

    // before about 16 percent of the bytes, unless send_steady is set, the sender idles for a random gap
    task automatic send_byte(input logic [7:0] b);
        if (!send_steady && $urandom_range(99) < 16) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'($urandom);
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        board.take_byte(b);
    endtask

    // sender waits until every pair has reported, then lets the engine go quiet
    task automatic drain();
        while (board.verdicts_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] len_val, input int budget);
        int          eff;
        int          kind;
        logic [63:0] mask;
        logic [63:0] a;
        logic [63:0] c;
        logic [7:0]  corner[4] = '{8'h00, 8'hFF, 8'h01, 8'h80};
        logic [7:0]  stream[$];
        write_length(len_val);
        eff  = coprime_tally::effective_length(len_val);
        mask = (eff == 8) ? '1 : ((64'd1 << (8 * eff)) - 64'd1);
        while (stream.size() < budget) begin
            a    = {$urandom, $urandom};
            c    = {$urandom, $urandom};
            kind = $urandom_range(0, 9);
            case (kind)
                5: c = a;
                6: begin
                    a[0] = 1'b0;
                    c[0] = 1'b0;
                end
                7: begin
                    if ($urandom_range(1)) a = '0; else c = '0;
                    if ($urandom_range(1)) begin
                        if (a == 0) c = 64'd1; else a = 64'd1;
                    end
                end
                8: begin
                    for (int i = 0; i < 8; i++) begin
                        a[8*i +: 8] = corner[$urandom_range(3)];
                        c[8*i +: 8] = corner[$urandom_range(3)];
                    end
                end
                9: c = (a & mask) + 64'd1;
                default: ;
            endcase
            a &= mask;
            c &= mask;
            for (int i = eff - 1; i >= 0; i--) stream.push_back(a[8*i +: 8]);
            for (int i = eff - 1; i >= 0; i--) stream.push_back(c[8*i +: 8]);
        end
        // budget rarely lines up with a pair, so the next length lands mid-number
        for (int n = 0; n < budget; n++) send_byte(stream[n]);
        s_axis_tvalid <= 1'b0;
        drain();
    endtask

    // receiver: random back-pressure, a steady stretch, and one long hold on request
    initial begin
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if (long_hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                long_hold_req = 1'b0;
            end
            m_axis_tready <= recv_steady ? 1'b1 : ($urandom_range(99) >= 24);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            board.check_verdict(m_axis_tdata);
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Mismatches found");
        $finish;
    end

    initial begin
        static logic [7:0]       wide_pair[10] = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                                                   8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFE};
        // zero/zero, zero/one, one/zero, max/max, fibonacci, powers of two, multiple
        static logic [7:0]       byte_pairs[14] = '{8'h00, 8'h00, 8'h00, 8'h01, 8'h01,
                                                    8'h00, 8'hFF, 8'hFF, 8'hE9, 8'h90,
                                                    8'h80, 8'h40, 8'hFE, 8'h7F};
        static logic [CFG_W-1:0] lengths[15] = '{4'd0, 4'd15, 4'd8, 4'd2, 4'd9, 4'd3,
                                                 4'd1, 4'd4, 4'd6, 4'd7, 4'd12, 4'd10,
                                                 4'd5, 4'd8, 4'd1};
        send_steady   = 1'b0;
        recv_steady   = 1'b0;
        long_hold_req = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset length of five bytes: consecutive maxima
        foreach (wide_pair[i]) send_byte(wide_pair[i]);
        s_axis_tvalid <= 1'b0;
        drain();
        write_length(4'd1);
        foreach (byte_pairs[i]) send_byte(byte_pairs[i]);
        s_axis_tvalid <= 1'b0;
        drain();

        foreach (lengths[p]) begin
            if (p == 3) begin
                // receiver stalls while bytes keep coming, so the pair queue backs up
                send_steady   = 1'b1;
                long_hold_req = 1'b1;
                run_phase(lengths[p], 110);
                send_steady   = 1'b0;
            end else if (p == 6) begin
                send_steady = 1'b1;
                recv_steady = 1'b1;
                run_phase(lengths[p], 100);
                send_steady = 1'b0;
                recv_steady = 1'b0;
            end else begin
                run_phase(lengths[p], $urandom_range(70, 100));
            end
        end

        if (board.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- filelist.f -----
+incdir+hdl
hdl/cpc_pkg.sv
hdl/cpc_front.sv
hdl/cpc_queue.sv
hdl/cpc_back.sv
hdl/coprime_pair_counter_top.sv
hdl/cpc_checker.sv
sim/coprime_pair_counter_top_tb.sv
